@@ sv/lrs_pkg.sv @@
// Shared widths, event codes, register indexes and reset values for the
// link reconnect supervisor. No dependencies.
`default_nettype none

package lrs_pkg;

    localparam int unsigned TYPE_W    = 4;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned BACKOFF_W = 17;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned LIM16_W   = 16;

    localparam logic [TYPE_W-1:0] EVT_POLL      = 4'd0;
    localparam logic [TYPE_W-1:0] EVT_CONNECTED = 4'd1;
    localparam logic [TYPE_W-1:0] EVT_DISCONN   = 4'd2;
    localparam logic [TYPE_W-1:0] EVT_ERROR     = 4'd3;
    localparam logic [TYPE_W-1:0] EVT_READY     = 4'd4;
    localparam logic [TYPE_W-1:0] EVT_SEND_OK   = 4'd5;
    localparam logic [TYPE_W-1:0] EVT_SEND_FAIL = 4'd6;
    localparam logic [TYPE_W-1:0] EVT_LINK_UP   = 4'd7;
    localparam logic [TYPE_W-1:0] EVT_LINK_DOWN = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_INIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READY_TMO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TMO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFAIL_LIM  = 3'd5;

    localparam logic [LIM16_W-1:0]   RST_BACKOFF_INIT = 16'd2000;
    localparam logic [LIM16_W-1:0]   RST_BACKOFF_MAX  = 16'd30000;
    localparam logic [TIME_W-1:0]    RST_READY_TMO    = 32'd15000;
    localparam logic [TIME_W-1:0]    RST_CONNECT_TMO  = 32'd10000;
    localparam logic [CNT_W-1:0]     RST_SEND_LIMIT   = 8'd3;
    localparam logic [CNT_W-1:0]     RST_PREFAIL_LIM  = 8'd3;
    localparam logic [BACKOFF_W-1:0] RST_BACKOFF      = 17'd2000;
    localparam logic [CNT_W-1:0]     STREAK_MAX       = 8'd255;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [TIME_W-1:0] now_ms;
        logic              link_up;
        logic              service_enabled;
        logic              socket_open;
    } t_req;

    typedef struct packed {
        logic                 ready_out;
        logic                 do_disconnect;
        logic                 do_connect;
        logic                 do_link_rebuild;
        logic                 do_discard_tx;
        logic                 do_new_session;
        logic                 do_notify_stop;
        logic                 do_bump_generation;
        logic [BACKOFF_W-1:0] backoff_now;
    } t_rsp;

endpackage

`default_nettype wire

@@ sv/lrs_req_if.sv @@
// Event channel: valid/ready handshake with the event payload.
// Depends on lrs_pkg.
`default_nettype none

interface lrs_req_if
    import lrs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [TIME_W-1:0] now_ms;
    logic              link_up;
    logic              service_enabled;
    logic              socket_open;

    modport source (
        output valid, req_type, now_ms, link_up, service_enabled, socket_open,
        input  ready
    );
    modport sink (
        input  valid, req_type, now_ms, link_up, service_enabled, socket_open,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/lrs_rsp_if.sv @@
// Result channel: valid/ready handshake with ready flag, action pulses
// and backoff. Depends on lrs_pkg.
`default_nettype none

interface lrs_rsp_if
    import lrs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 ready_out;
    logic                 do_disconnect;
    logic                 do_connect;
    logic                 do_link_rebuild;
    logic                 do_discard_tx;
    logic                 do_new_session;
    logic                 do_notify_stop;
    logic                 do_bump_generation;
    logic [BACKOFF_W-1:0] backoff_now;

    modport source (
        output valid, ready_out, do_disconnect, do_connect, do_link_rebuild,
               do_discard_tx, do_new_session, do_notify_stop,
               do_bump_generation, backoff_now,
        input  ready
    );
    modport sink (
        input  valid, ready_out, do_disconnect, do_connect, do_link_rebuild,
               do_discard_tx, do_new_session, do_notify_stop,
               do_bump_generation, backoff_now,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/link_reconnect_supervisor.sv @@
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while the result side does not stall; a
// stalled result holds at most one extra item in the input register.
// Reset (synchronous, active low) clears supervisor state to none/zero,
// backoff to 2000 ms and the configuration registers to their defaults.
// Depends on lrs_pkg, lrs_req_if, lrs_rsp_if.
`default_nettype none

module link_reconnect_supervisor
    import lrs_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    lrs_req_if.sink             i_req,
    lrs_rsp_if.source           o_rsp,
    input  wire                 i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [CFG_DAT_W-1:0] i_cfg_wdata
);

    // configuration
    logic [LIM16_W-1:0] r_cfg_backoff_init;
    logic [LIM16_W-1:0] r_cfg_backoff_max;
    logic [TIME_W-1:0]  r_cfg_ready_tmo;
    logic [TIME_W-1:0]  r_cfg_connect_tmo;
    logic [CNT_W-1:0]   r_cfg_send_limit;
    logic [CNT_W-1:0]   r_cfg_prefail_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_backoff_init <= RST_BACKOFF_INIT;
            r_cfg_backoff_max  <= RST_BACKOFF_MAX;
            r_cfg_ready_tmo    <= RST_READY_TMO;
            r_cfg_connect_tmo  <= RST_CONNECT_TMO;
            r_cfg_send_limit   <= RST_SEND_LIMIT;
            r_cfg_prefail_lim  <= RST_PREFAIL_LIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BACKOFF_INIT: r_cfg_backoff_init <= i_cfg_wdata[LIM16_W-1:0];
                CFG_BACKOFF_MAX:  r_cfg_backoff_max  <= i_cfg_wdata[LIM16_W-1:0];
                CFG_READY_TMO:    r_cfg_ready_tmo    <= i_cfg_wdata[TIME_W-1:0];
                CFG_CONNECT_TMO:  r_cfg_connect_tmo  <= i_cfg_wdata[TIME_W-1:0];
                CFG_SEND_LIMIT:   r_cfg_send_limit   <= i_cfg_wdata[CNT_W-1:0];
                CFG_PREFAIL_LIM:  r_cfg_prefail_lim  <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_rsp r_out;
    logic advance;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.req_type        <= i_req.req_type;
            r_in.now_ms          <= i_req.now_ms;
            r_in.link_up         <= i_req.link_up;
            r_in.service_enabled <= i_req.service_enabled;
            r_in.socket_open     <= i_req.socket_open;
        end
    end

    // supervisor state
    logic                 r_is_ready,     n_is_ready;
    logic [TIME_W-1:0]    r_connected_at, n_connected_at;
    logic [TIME_W-1:0]    r_attempt,      n_attempt;
    logic [TIME_W-1:0]    r_last_attempt, n_last_attempt;
    logic [BACKOFF_W-1:0] r_backoff,      n_backoff;
    logic [CNT_W-1:0]     r_send_fail,    n_send_fail;
    logic [CNT_W-1:0]     r_prefail,      n_prefail;
    logic                 r_self_closed,  n_self_closed;
    t_rsp                 n_out;

    // shared pre-ready failure update
    logic [CNT_W-1:0]     pf_inc;
    logic                 pf_rebuild;
    logic [CNT_W-1:0]     pf_cnt;
    logic [BACKOFF_W:0]   pf_dbl;
    logic [BACKOFF_W-1:0] pf_backoff;
    logic [BACKOFF_W-1:0] bmax_ext;
    logic [BACKOFF_W-1:0] binit_ext;
    logic [CNT_W-1:0]     sf_inc;
    logic [TIME_W-1:0]    el_conn, el_att, el_last;
    logic [TIME_W-1:0]    att_seen;

    assign bmax_ext  = {1'b0, r_cfg_backoff_max};
    assign binit_ext = {1'b0, r_cfg_backoff_init};
    assign pf_inc    = (r_prefail < STREAK_MAX) ? r_prefail + 1'b1 : r_prefail;
    assign pf_rebuild = (pf_inc >= r_cfg_prefail_lim);
    assign pf_cnt    = pf_rebuild ? '0 : pf_inc;
    assign pf_dbl    = {r_backoff, 1'b0};

    always_comb begin
        pf_backoff = r_backoff;
        if (r_backoff < bmax_ext) begin
            pf_backoff = (pf_dbl > {1'b0, bmax_ext}) ? bmax_ext
                                                      : pf_dbl[BACKOFF_W-1:0];
        end
    end

    assign sf_inc  = (r_send_fail < STREAK_MAX) ? r_send_fail + 1'b1 : r_send_fail;
    assign el_conn = r_in.now_ms - r_connected_at;
    assign el_att  = r_in.now_ms - r_attempt;
    assign el_last = r_in.now_ms - r_last_attempt;
    // a ready link that drops its socket clears the attempt stamp first
    assign att_seen = r_is_ready ? '0 : r_attempt;

    always_comb begin
        n_is_ready     = r_is_ready;
        n_connected_at = r_connected_at;
        n_attempt      = r_attempt;
        n_last_attempt = r_last_attempt;
        n_backoff      = r_backoff;
        n_send_fail    = r_send_fail;
        n_prefail      = r_prefail;
        n_self_closed  = r_self_closed;
        n_out          = '0;

        unique case (r_in.req_type)
            EVT_POLL: begin
                if (!r_in.link_up) begin
                    if (r_is_ready) begin
                        n_is_ready = 1'b0;
                        n_connected_at = '0;
                        n_attempt = '0;
                        n_out.do_notify_stop = 1'b1;
                    end
                end else if (!r_in.service_enabled) begin
                end else if (r_in.socket_open && r_is_ready) begin
                    n_attempt = '0;
                end else if (r_in.socket_open) begin
                    if (r_connected_at != '0 && el_conn > r_cfg_ready_tmo) begin
                        n_prefail = pf_cnt;
                        n_backoff = pf_backoff;
                        n_out.do_link_rebuild = pf_rebuild;
                        n_out.do_disconnect = 1'b1;
                        n_out.do_notify_stop = 1'b1;
                        n_is_ready = 1'b0;
                        n_connected_at = '0;
                        n_attempt = '0;
                    end
                end else begin
                    if (r_is_ready) begin
                        n_is_ready = 1'b0;
                        n_connected_at = '0;
                        n_attempt = '0;
                        n_out.do_notify_stop = 1'b1;
                    end
                    if (att_seen != '0) begin
                        if (el_att > r_cfg_connect_tmo) begin
                            n_prefail = pf_cnt;
                            n_backoff = pf_backoff;
                            n_out.do_link_rebuild = pf_rebuild;
                            n_out.do_disconnect = 1'b1;
                            n_out.do_notify_stop = 1'b1;
                            n_is_ready = 1'b0;
                            n_connected_at = '0;
                            n_attempt = '0;
                        end
                    end else if (r_last_attempt != '0 &&
                                 el_last < {{(TIME_W-BACKOFF_W){1'b0}}, r_backoff}) begin
                    end else begin
                        n_last_attempt = r_in.now_ms;
                        n_attempt = r_in.now_ms;
                        n_self_closed = 1'b1;
                        n_is_ready = 1'b0;
                        n_connected_at = '0;
                        n_out.do_disconnect = 1'b1;
                        n_out.do_new_session = 1'b1;
                        n_out.do_connect = 1'b1;
                    end
                end
            end
            EVT_CONNECTED: begin
                n_is_ready = 1'b0;
                n_connected_at = r_in.now_ms;
            end
            EVT_DISCONN, EVT_ERROR: begin
                n_self_closed = 1'b0;
                if (!r_is_ready && !r_self_closed) begin
                    n_prefail = pf_cnt;
                    n_backoff = pf_backoff;
                    n_out.do_link_rebuild = pf_rebuild;
                end
                n_is_ready = 1'b0;
                n_connected_at = '0;
                n_attempt = '0;
                n_out.do_notify_stop = 1'b1;
                n_out.do_discard_tx = 1'b1;
            end
            EVT_READY: begin
                n_backoff = binit_ext;
                n_attempt = '0;
                n_send_fail = '0;
                n_prefail = '0;
                n_is_ready = 1'b1;
            end
            EVT_SEND_OK: begin
                n_send_fail = '0;
            end
            EVT_SEND_FAIL: begin
                n_send_fail = sf_inc;
                if (sf_inc >= r_cfg_send_limit) begin
                    n_send_fail = '0;
                    n_self_closed = 1'b1;
                    n_is_ready = 1'b0;
                    n_connected_at = '0;
                    n_attempt = '0;
                    n_last_attempt = '0;
                    n_out.do_discard_tx = 1'b1;
                    n_out.do_disconnect = 1'b1;
                    n_out.do_notify_stop = 1'b1;
                    n_out.do_new_session = 1'b1;
                end
            end
            EVT_LINK_UP: begin
                n_backoff = binit_ext;
                n_last_attempt = '0;
                n_send_fail = '0;
                n_prefail = '0;
                n_is_ready = 1'b0;
                n_connected_at = '0;
                n_attempt = '0;
                n_out.do_notify_stop = 1'b1;
            end
            EVT_LINK_DOWN: begin
                n_send_fail = '0;
                n_self_closed = 1'b1;
                n_is_ready = 1'b0;
                n_connected_at = '0;
                n_attempt = '0;
                n_last_attempt = '0;
                n_out.do_bump_generation = 1'b1;
                n_out.do_discard_tx = 1'b1;
                n_out.do_disconnect = 1'b1;
                n_out.do_notify_stop = 1'b1;
                n_out.do_new_session = 1'b1;
            end
            default: ;
        endcase

        n_out.ready_out   = n_is_ready;
        n_out.backoff_now = n_backoff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_ready     <= 1'b0;
            r_connected_at <= '0;
            r_attempt      <= '0;
            r_last_attempt <= '0;
            r_backoff      <= RST_BACKOFF;
            r_send_fail    <= '0;
            r_prefail      <= '0;
            r_self_closed  <= 1'b0;
        end else if (advance) begin
            r_is_ready     <= n_is_ready;
            r_connected_at <= n_connected_at;
            r_attempt      <= n_attempt;
            r_last_attempt <= n_last_attempt;
            r_backoff      <= n_backoff;
            r_send_fail    <= n_send_fail;
            r_prefail      <= n_prefail;
            r_self_closed  <= n_self_closed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.ready_out          = r_out.ready_out;
    assign o_rsp.do_disconnect      = r_out.do_disconnect;
    assign o_rsp.do_connect         = r_out.do_connect;
    assign o_rsp.do_link_rebuild    = r_out.do_link_rebuild;
    assign o_rsp.do_discard_tx      = r_out.do_discard_tx;
    assign o_rsp.do_new_session     = r_out.do_new_session;
    assign o_rsp.do_notify_stop     = r_out.do_notify_stop;
    assign o_rsp.do_bump_generation = r_out.do_bump_generation;
    assign o_rsp.backoff_now        = r_out.backoff_now;

endmodule

`default_nettype wire

@@ bench/tb_link_reconnect_supervisor.sv @@
`timescale 1ns / 100ps
// Self-checking bench for link_reconnect_supervisor: directed event table, then
// scripted connect sessions with noise under several register settings.
// Depends on lrs_pkg, lrs_req_if, lrs_rsp_if and the supervisor RTL.

module tb_link_reconnect_supervisor;
    import lrs_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned PHASE_ITEMS   = 65;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam logic [TYPE_W-1:0] EVT_BAD_LO = EVT_LINK_DOWN + 1'b1;
    localparam logic [TYPE_W-1:0] EVT_BAD_HI = '1;

    typedef struct {
        t_req ev;
        bit   typed;
        t_rsp want;
    } t_script_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;

    lrs_req_if ev_if ();
    lrs_rsp_if res_if ();

    link_reconnect_supervisor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (ev_if),
        .o_rsp       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // supervisor model state and register copies
    bit          st_ready;
    int unsigned st_conn_at;
    int unsigned st_attempt_at;
    int unsigned st_last_try;
    int unsigned st_backoff;
    int unsigned st_send_fails;
    int unsigned st_prefails;
    bit          st_self_closed;
    int unsigned cf_init;
    int unsigned cf_max;
    int unsigned cf_rdy_tmo;
    int unsigned cf_conn_tmo;
    int unsigned cf_send_lim;
    int unsigned cf_pre_lim;
    t_rsp        acts;

    t_rsp        expected_actions[$];
    t_script_row script[$];
    int unsigned n_fail;
    int unsigned n_checked;
    int unsigned n_sent;
    int unsigned n_settings;
    int unsigned phase_items;
    int unsigned clk_ms;
    bit          no_idle;
    bit          hold_request;
    int unsigned cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic void model_reset();
        cf_init        = RST_BACKOFF_INIT;
        cf_max         = RST_BACKOFF_MAX;
        cf_rdy_tmo     = RST_READY_TMO;
        cf_conn_tmo    = RST_CONNECT_TMO;
        cf_send_lim    = RST_SEND_LIMIT;
        cf_pre_lim     = RST_PREFAIL_LIM;
        st_ready       = 1'b0;
        st_conn_at     = 0;
        st_attempt_at  = 0;
        st_last_try    = 0;
        st_backoff     = RST_BACKOFF;
        st_send_fails  = 0;
        st_prefails    = 0;
        st_self_closed = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_BACKOFF_INIT: cf_init     = data[LIM16_W-1:0];
            CFG_BACKOFF_MAX:  cf_max      = data[LIM16_W-1:0];
            CFG_READY_TMO:    cf_rdy_tmo  = data;
            CFG_CONNECT_TMO:  cf_conn_tmo = data;
            CFG_SEND_LIMIT:   cf_send_lim = data[CNT_W-1:0];
            CFG_PREFAIL_LIM:  cf_pre_lim  = data[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void drop_link();
        st_ready            = 1'b0;
        st_conn_at          = 0;
        st_attempt_at       = 0;
        acts.do_notify_stop = 1'b1;
    endfunction

    function automatic void count_prefail();
        if (st_prefails < STREAK_MAX)
            st_prefails++;
        if (st_backoff < cf_max) begin
            st_backoff = st_backoff * 2;
            if (st_backoff > cf_max)
                st_backoff = cf_max;
        end
        st_backoff &= 32'h1FFFF;
        if (st_prefails >= cf_pre_lim) begin
            st_prefails          = 0;
            acts.do_link_rebuild = 1'b1;
        end
    endfunction

    function automatic void timeout_drop();
        count_prefail();
        acts.do_disconnect = 1'b1;
        drop_link();
        st_attempt_at = 0;
    endfunction

    function automatic void restart_session();
        st_send_fails       = 0;
        acts.do_discard_tx  = 1'b1;
        st_self_closed      = 1'b1;
        acts.do_disconnect  = 1'b1;
        drop_link();
        acts.do_new_session = 1'b1;
        st_last_try         = 0;
        st_attempt_at       = 0;
    endfunction

    function automatic void poll_tick(input logic [TIME_W-1:0] now,
                                      input logic link, svc, sock);
        if (!link) begin
            if (st_ready)
                drop_link();
        end else if (svc) begin
            if (sock && st_ready) begin
                st_attempt_at = 0;
            end else if (sock) begin
                if (st_conn_at != 0 && (now - st_conn_at) > cf_rdy_tmo)
                    timeout_drop();
            end else begin
                if (st_ready)
                    drop_link();
                if (st_attempt_at != 0) begin
                    if ((now - st_attempt_at) > cf_conn_tmo)
                        timeout_drop();
                end else if (st_last_try == 0 || (now - st_last_try) >= st_backoff) begin
                    st_last_try         = now;
                    st_attempt_at       = now;
                    st_self_closed      = 1'b1;
                    acts.do_disconnect  = 1'b1;
                    st_ready            = 1'b0;
                    st_conn_at          = 0;
                    acts.do_new_session = 1'b1;
                    acts.do_connect     = 1'b1;
                end
            end
        end
    endfunction

    function automatic t_rsp predict_event(input t_req ev);
        acts = '0;
        case (ev.req_type)
            EVT_POLL: poll_tick(ev.now_ms, ev.link_up, ev.service_enabled, ev.socket_open);
            EVT_CONNECTED: begin
                st_ready   = 1'b0;
                st_conn_at = ev.now_ms;
            end
            EVT_DISCONN, EVT_ERROR: begin
                if (!st_ready && !st_self_closed)
                    count_prefail();
                st_self_closed = 1'b0;
                drop_link();
                acts.do_discard_tx = 1'b1;
            end
            EVT_READY: begin
                st_backoff    = cf_init;
                st_attempt_at = 0;
                st_send_fails = 0;
                st_prefails   = 0;
                st_ready      = 1'b1;
            end
            EVT_SEND_OK: st_send_fails = 0;
            EVT_SEND_FAIL: begin
                if (st_send_fails < STREAK_MAX)
                    st_send_fails++;
                if (st_send_fails >= cf_send_lim)
                    restart_session();
            end
            EVT_LINK_UP: begin
                st_backoff    = cf_init;
                st_last_try   = 0;
                st_send_fails = 0;
                st_prefails   = 0;
                drop_link();
            end
            EVT_LINK_DOWN: begin
                acts.do_bump_generation = 1'b1;
                restart_session();
            end
            default: ;
        endcase
        acts.ready_out   = st_ready;
        acts.backoff_now = st_backoff[BACKOFF_W-1:0];
        return acts;
    endfunction

    function automatic t_req mk_ev(input logic [TYPE_W-1:0] kind,
                                   input logic [TIME_W-1:0] now,
                                   input logic link, svc, sock);
        t_req ev;
        ev.req_type        = kind;
        ev.now_ms          = now;
        ev.link_up         = link;
        ev.service_enabled = svc;
        ev.socket_open     = sock;
        return ev;
    endfunction

    function automatic t_rsp pack_rsp(input logic rdy, disc, conn, rebuild, discard,
                                      input logic newsess, stop, bump,
                                      input logic [BACKOFF_W-1:0] boff);
        t_rsp r;
        r.ready_out          = rdy;
        r.do_disconnect      = disc;
        r.do_connect         = conn;
        r.do_link_rebuild    = rebuild;
        r.do_discard_tx      = discard;
        r.do_new_session     = newsess;
        r.do_notify_stop     = stop;
        r.do_bump_generation = bump;
        r.backoff_now        = boff;
        return r;
    endfunction

    function automatic void add_row(input t_req ev, input bit typed, input t_rsp want);
        t_script_row row;
        row.ev    = ev;
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void advance_clock();
        int unsigned r;
        r = $urandom_range(0, 199);
        if (r == 0)
            clk_ms = 0;
        else if (r < 3)
            clk_ms = $urandom;
        else if (r < 100)
            clk_ms += $urandom_range(0, 300);
        else if (r < 160)
            clk_ms += $urandom_range(300, 3000);
        else if (r < 190)
            clk_ms += $urandom_range(3000, 20000);
        else
            clk_ms += $urandom_range(20000, 70000);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (expected_actions.size() == 0) begin
                $error("result item with no expectation pending");
                n_fail++;
            end else begin
                want = expected_actions.pop_front();
                n_checked++;
                check_field("ready_out", want.ready_out, res_if.ready_out);
                check_field("do_disconnect", want.do_disconnect, res_if.do_disconnect);
                check_field("do_connect", want.do_connect, res_if.do_connect);
                check_field("do_link_rebuild", want.do_link_rebuild, res_if.do_link_rebuild);
                check_field("do_discard_tx", want.do_discard_tx, res_if.do_discard_tx);
                check_field("do_new_session", want.do_new_session, res_if.do_new_session);
                check_field("do_notify_stop", want.do_notify_stop, res_if.do_notify_stop);
                check_field("do_bump_generation", want.do_bump_generation,
                            res_if.do_bump_generation);
                check_field("backoff_now", want.backoff_now, res_if.backoff_now);
            end
        end
    end

    // result side: random stalls, calm stretches, long hold on request
    initial begin
        int unsigned hold_left;
        int unsigned calm_left;
        int unsigned r;
        hold_left    = 0;
        calm_left    = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (calm_left != 0) begin
                calm_left--;
                res_if.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    calm_left = $urandom_range(20, 80);
                else if (r < 4)
                    hold_left = $urandom_range(8, 40);
                res_if.ready <= (r < 2) || (r >= 4 && r < 70);
            end
        end
    end

    task automatic offer_event(input t_req ev, input bit typed, input t_rsp typed_rsp);
        t_rsp        want;
        int unsigned gap;
        ev_if.valid           <= 1'b1;
        ev_if.req_type        <= ev.req_type;
        ev_if.now_ms          <= ev.now_ms;
        ev_if.link_up         <= ev.link_up;
        ev_if.service_enabled <= ev.service_enabled;
        ev_if.socket_open     <= ev.socket_open;
        @(posedge i_clk);
        while (!ev_if.ready)
            @(posedge i_clk);
        want = predict_event(ev);
        if (typed)
            want = typed_rsp;
        expected_actions.push_back(want);
        n_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            ev_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_out();
        ev_if.valid <= 1'b0;
        while (expected_actions.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_registers(input logic [CFG_DAT_W-1:0] b_init, b_max, rdy_tmo,
                                 input logic [CFG_DAT_W-1:0] conn_tmo, slim, plim);
        logic [CFG_DAT_W-1:0] vals [6];
        logic [CFG_IDX_W-1:0] idxs [6];
        vals = '{b_init, b_max, rdy_tmo, conn_tmo, slim, plim};
        idxs = '{CFG_BACKOFF_INIT, CFG_BACKOFF_MAX, CFG_READY_TMO,
                 CFG_CONNECT_TMO, CFG_SEND_LIMIT, CFG_PREFAIL_LIM};
        wait_all_out();
        for (int k = 0; k < 6; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idxs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            apply_reg(idxs[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic fire(input logic [TYPE_W-1:0] kind, input logic link, svc, sock);
        advance_clock();
        offer_event(mk_ev(kind, clk_ms, link, svc, sock), 1'b0, '0);
        if (kind <= EVT_LINK_DOWN)
            phase_items++;
    endtask

    task automatic fire_noise();
        fire(TYPE_W'($urandom_range(0, EVT_BAD_HI)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // one connect attempt through ready, traffic and a loss; sometimes pure noise
    task automatic run_session();
        int unsigned r;
        no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) fire_noise();
        end else begin
            repeat ($urandom_range(1, 3)) fire(EVT_POLL, 1'b1, 1'b1, 1'b0);
            fire(EVT_CONNECTED, 1'b1, 1'b1, 1'b1);
            repeat ($urandom_range(0, 2)) fire(EVT_POLL, 1'b1, 1'b1, 1'b1);
            if ($urandom_range(0, 3) != 0) begin
                fire(EVT_READY, 1'b1, 1'b1, 1'b1);
                repeat ($urandom_range(0, 8)) begin
                    r = $urandom_range(0, 9);
                    if (r < 5)
                        fire(EVT_SEND_FAIL, 1'b1, 1'b1, 1'b1);
                    else if (r < 8)
                        fire(EVT_SEND_OK, 1'b1, 1'b1, 1'b1);
                    else
                        fire(EVT_POLL, 1'b1, 1'b1, 1'b1);
                end
            end
            case ($urandom_range(0, 5))
                0: fire(EVT_DISCONN, 1'b1, 1'b1, 1'b0);
                1: fire(EVT_ERROR, 1'b1, 1'b1, 1'b0);
                2: fire(EVT_LINK_DOWN, 1'b0, 1'b1, 1'b0);
                3: fire(EVT_LINK_UP, 1'b1, 1'b1, 1'b0);
                4: fire(EVT_POLL, 1'b1, 1'b1, 1'b0);
                default: fire(EVT_POLL, 1'b0, 1'b1, 1'b0);
            endcase
            if ($urandom_range(0, 7) == 0)
                fire_noise();
        end
    endtask

    task automatic run_phase();
        phase_items = 0;
        while (phase_items < PHASE_ITEMS)
            run_session();
    endtask

    initial begin
        int unsigned n_directed;
        ev_if.valid           = 1'b0;
        ev_if.req_type        = EVT_POLL;
        ev_if.now_ms          = '0;
        ev_if.link_up         = 1'b0;
        ev_if.service_enabled = 1'b0;
        ev_if.socket_open     = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_BACKOFF_INIT;
        i_cfg_wdata           = '0;
        i_rst_n               = 1'b0;
        hold_request          = 1'b0;
        no_idle               = 1'b0;
        n_fail                = 0;
        n_checked             = 0;
        n_sent                = 0;
        n_settings            = 1;
        clk_ms                = $urandom;
        model_reset();

        // default registers; hand-derived results where obvious
        add_row(mk_ev(EVT_POLL, 1000, 0, 1, 0), 1,
                pack_rsp(0, 0, 0, 0, 0, 0, 0, 0, RST_BACKOFF));
        add_row(mk_ev(EVT_BAD_HI, '1, 1, 1, 1), 1,
                pack_rsp(0, 0, 0, 0, 0, 0, 0, 0, RST_BACKOFF));
        add_row(mk_ev(EVT_POLL, 1000, 1, 0, 0), 1,
                pack_rsp(0, 0, 0, 0, 0, 0, 0, 0, RST_BACKOFF));
        add_row(mk_ev(EVT_POLL, 1000, 1, 1, 0), 1,
                pack_rsp(0, 1, 1, 0, 0, 1, 0, 0, RST_BACKOFF));
        add_row(mk_ev(EVT_POLL, 5000, 1, 1, 0), 0, '0);
        add_row(mk_ev(EVT_POLL, 11001, 1, 1, 0), 1,
                pack_rsp(0, 1, 0, 0, 0, 0, 1, 0, 17'd4000));
        add_row(mk_ev(EVT_POLL, 12000, 1, 1, 0), 0, '0);
        add_row(mk_ev(EVT_CONNECTED, 13000, 1, 1, 1), 0, '0);
        add_row(mk_ev(EVT_POLL, 20000, 1, 1, 1), 0, '0);
        add_row(mk_ev(EVT_READY, 21000, 1, 1, 1), 1,
                pack_rsp(1, 0, 0, 0, 0, 0, 0, 0, RST_BACKOFF));
        add_row(mk_ev(EVT_SEND_FAIL, 21100, 1, 1, 1), 0, '0);
        add_row(mk_ev(EVT_SEND_FAIL, 21200, 1, 1, 1), 0, '0);
        add_row(mk_ev(EVT_SEND_FAIL, 21300, 1, 1, 1), 0, '0);
        add_row(mk_ev(EVT_DISCONN, 21400, 1, 1, 0), 0, '0);
        add_row(mk_ev(EVT_LINK_DOWN, 21500, 0, 0, 0), 0, '0);
        add_row(mk_ev(EVT_LINK_UP, 0, 1, 1, 0), 0, '0);
        add_row(mk_ev(EVT_ERROR, 100, 1, 1, 0), 0, '0);
        add_row(mk_ev(EVT_ERROR, 200, 1, 1, 0), 0, '0);
        add_row(mk_ev(EVT_CONNECTED, 0, 1, 1, 1), 0, '0);
        add_row(mk_ev(EVT_POLL, 32'd4000000000, 1, 1, 1), 0, '0);
        add_row(mk_ev(EVT_CONNECTED, '1, 1, 1, 1), 0, '0);
        add_row(mk_ev(EVT_POLL, 15000, 1, 1, 1), 0, '0);
        add_row(mk_ev(EVT_SEND_OK, 15100, 1, 1, 1), 0, '0);
        add_row(mk_ev(EVT_READY, 15200, 1, 1, 1), 0, '0);
        add_row(mk_ev(EVT_POLL, 15300, 1, 1, 1), 0, '0);
        add_row(mk_ev(EVT_POLL, 15400, 0, 1, 1), 0, '0);
        add_row(mk_ev(EVT_BAD_LO, 15500, 1, 1, 0), 0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i])
            offer_event(script[i].ev, script[i].typed, script[i].want);
        n_directed = n_sent;

        run_phase();

        set_registers(1, 65535, 0, 0, 1, 1);
        run_phase();

        // long result stall while the event side keeps offering back to back
        set_registers(65535, 65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 255, 255);
        hold_request = 1'b1;
        no_idle      = 1'b1;
        repeat (30) fire(TYPE_W'($urandom_range(0, EVT_LINK_DOWN)), 1'b1, 1'b1, 1'b1);
        run_phase();

        set_registers(0, 1, 100, 100, 0, 0);
        run_phase();

        // initial backoff above the cap
        set_registers(40000, 1000, 3000, 2000, 2, 4);
        run_phase();
        wait_all_out();
        run_phase();

        set_registers($urandom_range(1, 8000), $urandom_range(1, 65535),
                      $urandom_range(0, 40000), $urandom_range(0, 40000),
                      $urandom_range(0, 8), $urandom_range(0, 8));
        run_phase();

        set_registers(RST_BACKOFF_INIT, RST_BACKOFF_MAX, RST_READY_TMO, RST_CONNECT_TMO,
                      RST_SEND_LIMIT, RST_PREFAIL_LIM);
        run_phase();

        wait_all_out();
        $display("Sent %0d events (%0d from the directed table) under %0d register settings;",
                 n_sent, n_directed, n_settings);
        $display("checked %0d result items, %0d mismatches.", n_checked, n_fail);
        if (n_fail == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
